// File: sv/mtbd_pkg.sv
// ----------------------------------------------------------------------------
// mtbd_pkg
// Shared constants and types of the multi-tap bit-crushing delay: sizes,
// register fields and reset values, channel payloads and the memory request.
// ----------------------------------------------------------------------------
package mtbd_pkg;

  localparam int LINE_DEPTH = 262144;
  localparam int TAP_COUNT  = 8;

  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int RING_W = ADDR_W + 1;
  localparam int TAP_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

  localparam int SAMPLE_W = 16;

  // Configuration field widths.
  localparam int DELAY_W = 18;
  localparam int FB_W    = 15;
  localparam int DEPTH_W = 5;
  localparam int DECAY_W = 3;
  localparam int MIX_W   = 16;
  localparam int HOLD_W  = 4;
  localparam int RLEN_W  = 19;

  // Configuration port.
  localparam int REG_COUNT = 8;
  localparam int PADDR_W   = $clog2(REG_COUNT * 4);
  localparam int PDATA_W   = 32;

  // Arithmetic constants.
  localparam int Q15_ONE    = 32768;
  localparam int GAIN_FLOOR = 33;
  localparam int HOLD_MAX   = 8;
  localparam int HCNT_W     = $clog2(HOLD_MAX);

  // Register reset values.
  localparam int RST_DELAY    = 18000;
  localparam int RST_FEEDBACK = 18022;
  localparam int RST_DEPTH    = 16;
  localparam int RST_DECAY    = 2;
  localparam int RST_MIX      = 19661;
  localparam int RST_HOLD     = 1;
  localparam int RST_RING     = 192000;
  localparam int RST_STEREO   = 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } mix_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_length;
    logic [FB_W-1:0]    feedback_gain;
    logic [DEPTH_W-1:0] start_depth;
    logic [DECAY_W-1:0] depth_decay;
    logic [MIX_W-1:0]   wet_mix;
    logic [HOLD_W-1:0]  hold_factor;
    logic [RLEN_W-1:0]  ring_length;
    logic               stereo_mode;
  } cfg_t;

  typedef struct packed {
    logic                       we_l;
    logic                       we_r;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] wdata_l;
    logic signed [SAMPLE_W-1:0] wdata_r;
  } ram_req_t;

endpackage

// File: sv/mtbd_ram.sv
// ----------------------------------------------------------------------------
// mtbd_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mtbd_ram #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/mtbd_regs.sv
// ----------------------------------------------------------------------------
// mtbd_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module mtbd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mtbd_pkg::PADDR_W-1:0]   paddr,
  input  logic [mtbd_pkg::PDATA_W-1:0]   pwdata,
  output logic [mtbd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output mtbd_pkg::cfg_t                 cfg
);

  typedef enum logic [mtbd_pkg::PADDR_W-3:0] {
    REG_DELAY,
    REG_FEEDBACK,
    REG_DEPTH,
    REG_DECAY,
    REG_MIX,
    REG_HOLD,
    REG_RING,
    REG_STEREO
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[mtbd_pkg::PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_length  <= mtbd_pkg::DELAY_W'(mtbd_pkg::RST_DELAY);
      cfg.feedback_gain <= mtbd_pkg::FB_W'(mtbd_pkg::RST_FEEDBACK);
      cfg.start_depth   <= mtbd_pkg::DEPTH_W'(mtbd_pkg::RST_DEPTH);
      cfg.depth_decay   <= mtbd_pkg::DECAY_W'(mtbd_pkg::RST_DECAY);
      cfg.wet_mix       <= mtbd_pkg::MIX_W'(mtbd_pkg::RST_MIX);
      cfg.hold_factor   <= mtbd_pkg::HOLD_W'(mtbd_pkg::RST_HOLD);
      cfg.ring_length   <= mtbd_pkg::RLEN_W'(mtbd_pkg::RST_RING);
      cfg.stereo_mode   <= 1'(mtbd_pkg::RST_STEREO);
    end else if (wr) begin
      unique case (idx)
        REG_DELAY:    cfg.delay_length  <= pwdata[mtbd_pkg::DELAY_W-1:0];
        REG_FEEDBACK: cfg.feedback_gain <= pwdata[mtbd_pkg::FB_W-1:0];
        REG_DEPTH:    cfg.start_depth   <= pwdata[mtbd_pkg::DEPTH_W-1:0];
        REG_DECAY:    cfg.depth_decay   <= pwdata[mtbd_pkg::DECAY_W-1:0];
        REG_MIX:      cfg.wet_mix       <= pwdata[mtbd_pkg::MIX_W-1:0];
        REG_HOLD:     cfg.hold_factor   <= pwdata[mtbd_pkg::HOLD_W-1:0];
        REG_RING:     cfg.ring_length   <= pwdata[mtbd_pkg::RLEN_W-1:0];
        REG_STEREO:   cfg.stereo_mode   <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DELAY:    prdata = mtbd_pkg::PDATA_W'(cfg.delay_length);
      REG_FEEDBACK: prdata = mtbd_pkg::PDATA_W'(cfg.feedback_gain);
      REG_DEPTH:    prdata = mtbd_pkg::PDATA_W'(cfg.start_depth);
      REG_DECAY:    prdata = mtbd_pkg::PDATA_W'(cfg.depth_decay);
      REG_MIX:      prdata = mtbd_pkg::PDATA_W'(cfg.wet_mix);
      REG_HOLD:     prdata = mtbd_pkg::PDATA_W'(cfg.hold_factor);
      REG_RING:     prdata = mtbd_pkg::PDATA_W'(cfg.ring_length);
      REG_STEREO:   prdata = mtbd_pkg::PDATA_W'(cfg.stereo_mode);
    endcase
  end

endmodule

// File: sv/mtbd_core.sv
// ----------------------------------------------------------------------------
// mtbd_core
// Sequencer and datapath: clears the delay memories after reset, writes each
// sample pair at the head, walks the taps one at a time through the shared
// memory port and multipliers, and forms the saturated dry/wet mix.
// ----------------------------------------------------------------------------
module mtbd_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mtbd_pkg::cfg_t                       cfg,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  mtbd_pkg::sample_t                    sample,
  output mtbd_pkg::ram_req_t                   ram,
  input  logic signed [mtbd_pkg::SAMPLE_W-1:0] rd_l,
  input  logic signed [mtbd_pkg::SAMPLE_W-1:0] rd_r,
  input  logic                                 slot_free,
  output logic                                 res_valid,
  output mtbd_pkg::mix_t                       res
);

  localparam int ADDR_W  = mtbd_pkg::ADDR_W;
  localparam int RING_W  = mtbd_pkg::RING_W;
  localparam int TAP_W   = mtbd_pkg::TAP_W;
  localparam int SW      = mtbd_pkg::SAMPLE_W;
  localparam int HOLD_W  = mtbd_pkg::HOLD_W;
  localparam int HCNT_W  = mtbd_pkg::HCNT_W;
  localparam int MIX_W   = mtbd_pkg::MIX_W;
  localparam int GAIN_W  = 16;
  localparam int GPROD_W = GAIN_W + mtbd_pkg::FB_W;
  localparam int BITS_W  = 7;
  localparam int OFF_W   = mtbd_pkg::DELAY_W + $clog2(mtbd_pkg::TAP_COUNT + 1);
  localparam int CMP_W   = (OFF_W > RING_W) ? OFF_W : RING_W;
  localparam int PROD_W  = SW + GAIN_W;
  localparam int WET_W   = PROD_W + TAP_W;
  localparam int DRY_W   = SW + MIX_W + 1;
  localparam int WT_W    = WET_W + MIX_W + 1;
  localparam int SUM_W   = WT_W + 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_GAIN,
    ST_CHECK,
    ST_DATA,
    ST_MUL,
    ST_ACC,
    ST_MIX,
    ST_SUM,
    ST_DONE
  } state_t;

  state_t                     state;
  logic [ADDR_W-1:0]          clr_addr;
  logic [ADDR_W-1:0]          head;
  logic [TAP_W-1:0]           tap;
  logic signed [BITS_W-1:0]   bits;
  logic [GAIN_W-1:0]          gain;
  logic [GPROD_W-1:0]         gain_prod;
  logic [OFF_W-1:0]           offset;
  logic signed [SW-1:0]       dry_l;
  logic signed [SW-1:0]       dry_r;
  logic signed [SW-1:0]       crush_l;
  logic signed [SW-1:0]       crush_r;
  logic signed [PROD_W-1:0]   prod_l;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [WET_W-1:0]    wet_l;
  logic signed [WET_W-1:0]    wet_r;
  logic signed [DRY_W-1:0]    dry_term_l;
  logic signed [DRY_W-1:0]    dry_term_r;
  logic signed [WT_W-1:0]     wet_term_l;
  logic signed [WT_W-1:0]     wet_term_r;
  logic [HCNT_W-1:0]          hold_cnt;
  logic signed [SW-1:0]       held_l [mtbd_pkg::TAP_COUNT];
  logic signed [SW-1:0]       held_r [mtbd_pkg::TAP_COUNT];

  logic [RING_W-1:0]          ring_c;
  logic [HOLD_W-1:0]          hf_c;
  logic [MIX_W-1:0]           mix_c;
  logic [MIX_W-1:0]           inv_mix;
  logic                       stereo;
  logic                       off_hit;
  logic [RING_W-1:0]          off_r;
  logic [RING_W-1:0]          head_x;
  logic [RING_W-1:0]          pos_x;
  logic [ADDR_W-1:0]          pos;
  logic [GAIN_W-1:0]          gain_new;
  logic                       hold_on;
  logic                       refresh;
  logic signed [SW-1:0]       rd_r_eff;
  logic signed [SW-1:0]       samp_l;
  logic signed [SW-1:0]       samp_r;
  logic [HCNT_W-1:0]          hold_inc;
  logic [HCNT_W-1:0]          hold_next;
  logic [RING_W-1:0]          head_inc;
  logic [ADDR_W-1:0]          head_next;
  logic signed [SUM_W-1:0]    sum_l;
  logic signed [SUM_W-1:0]    sum_r;

  // Crushing to b bits clears the low 16-b bits of the sample.
  function automatic logic signed [SW-1:0] crush(input logic signed [SW-1:0] x,
                                                 input logic signed [BITS_W-1:0] b);
    logic [4:0]    sh;
    logic [SW-1:0] mask;
    sh   = 5'(7'sd16 - b);
    mask = {SW{1'b1}} << sh;
    if (b >= 7'sd16) begin
      return x;
    end
    return $signed(x & mask);
  endfunction

  // Floor of the sum over 2^30, saturated to 16 bits.
  function automatic logic signed [SW-1:0] sat_mix(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = v >>> 30;
    if (!s[SUM_W-1] && (|s[SUM_W-2:SW-1])) begin
      return 16'sh7FFF;
    end else if (s[SUM_W-1] && !(&s[SUM_W-2:SW-1])) begin
      return 16'sh8000;
    end
    return s[SW-1:0];
  endfunction

  // Clamped configuration.
  always_comb begin
    if (cfg.ring_length == '0) begin
      ring_c = RING_W'(1);
    end else if (32'(cfg.ring_length) > 32'(mtbd_pkg::LINE_DEPTH)) begin
      ring_c = RING_W'(mtbd_pkg::LINE_DEPTH);
    end else begin
      ring_c = RING_W'(cfg.ring_length);
    end
    if (cfg.hold_factor == '0) begin
      hf_c = HOLD_W'(1);
    end else if (cfg.hold_factor > HOLD_W'(mtbd_pkg::HOLD_MAX)) begin
      hf_c = HOLD_W'(mtbd_pkg::HOLD_MAX);
    end else begin
      hf_c = cfg.hold_factor;
    end
    if (cfg.wet_mix > MIX_W'(mtbd_pkg::Q15_ONE)) begin
      mix_c = MIX_W'(mtbd_pkg::Q15_ONE);
    end else begin
      mix_c = cfg.wet_mix;
    end
  end

  assign inv_mix = MIX_W'(mtbd_pkg::Q15_ONE) - mix_c;
  assign stereo  = cfg.stereo_mode;

  // Tap read address, valid whenever the offset is inside the ring.
  always_comb begin
    off_hit = CMP_W'(offset) >= CMP_W'(ring_c);
    off_r   = RING_W'(offset);
    head_x  = RING_W'(head);
    if (head_x >= off_r) begin
      pos_x = head_x - off_r;
    end else begin
      pos_x = head_x + ring_c - off_r;
    end
    pos = ADDR_W'(pos_x);
  end

  assign gain_new = GAIN_W'(gain_prod >> 15);

  // Sample-and-hold: with hold on, a tap refreshes its held pair when the shared counter is zero.
  assign hold_on  = hf_c > HOLD_W'(1);
  assign refresh  = !hold_on || (hold_cnt == '0);
  assign rd_r_eff = stereo ? rd_r : rd_l;
  assign samp_l   = refresh ? rd_l : held_l[tap];
  assign samp_r   = refresh ? rd_r_eff : held_r[tap];

  always_comb begin
    hold_inc = hold_cnt + 1'b1;
    if (HOLD_W'(hold_inc) >= hf_c) begin
      hold_next = '0;
    end else begin
      hold_next = hold_inc;
    end
    head_inc = head_x + 1'b1;
    if (head_inc >= ring_c) begin
      head_next = '0;
    end else begin
      head_next = ADDR_W'(head_inc);
    end
  end

  assign sum_l = (SUM_W'(dry_term_l) <<< 15) + SUM_W'(wet_term_l);
  assign sum_r = (SUM_W'(dry_term_r) <<< 15) + SUM_W'(wet_term_r);

  // Memory requests: clearing sweep, the head write, otherwise a tap read.
  always_comb begin
    ram.we_l    = 1'b0;
    ram.we_r    = 1'b0;
    ram.addr    = pos;
    ram.wdata_l = dry_l;
    ram.wdata_r = dry_r;
    priority if (state == ST_CLEAR) begin
      ram.we_l    = 1'b1;
      ram.we_r    = 1'b1;
      ram.addr    = clr_addr;
      ram.wdata_l = '0;
      ram.wdata_r = '0;
    end else if (state == ST_WRITE) begin
      ram.we_l = 1'b1;
      ram.we_r = stereo;
      ram.addr = head;
    end else begin
      ram.we_l = 1'b0;
    end
  end

  assign sample_stall = (state != ST_IDLE);
  assign res_valid    = (state == ST_DONE) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      head     <= '0;
      hold_cnt <= '0;
      for (int i = 0; i < mtbd_pkg::TAP_COUNT; i++) begin
        held_l[i] <= '0;
        held_r[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(mtbd_pkg::LINE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (sample_valid) begin
            dry_l <= sample.left_in;
            dry_r <= stereo ? sample.right_in : sample.left_in;
            // The ring may have shrunk below the head since the last item.
            if (head_x >= ring_c) begin
              head <= '0;
            end
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          tap    <= '0;
          bits   <= $signed(BITS_W'(cfg.start_depth));
          gain   <= GAIN_W'(mtbd_pkg::Q15_ONE);
          offset <= OFF_W'(cfg.delay_length);
          wet_l  <= '0;
          wet_r  <= '0;
          state  <= ST_GAIN;
        end
        ST_GAIN: begin
          if (bits < 7'sd1) begin
            state <= ST_MIX;
          end else begin
            gain_prod <= gain * cfg.feedback_gain;
            state     <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if ((gain_new < GAIN_W'(mtbd_pkg::GAIN_FLOOR)) || off_hit) begin
            state <= ST_MIX;
          end else begin
            gain  <= gain_new;
            state <= ST_DATA;
          end
        end
        ST_DATA: begin
          crush_l <= crush(samp_l, bits);
          crush_r <= crush(samp_r, bits);
          if (hold_on && (hold_cnt == '0)) begin
            held_l[tap] <= rd_l;
            held_r[tap] <= rd_r_eff;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod_l <= crush_l * $signed({1'b0, gain});
          prod_r <= crush_r * $signed({1'b0, gain});
          state  <= ST_ACC;
        end
        ST_ACC: begin
          wet_l  <= wet_l + WET_W'(prod_l);
          wet_r  <= wet_r + WET_W'(prod_r);
          bits   <= bits - $signed(BITS_W'(cfg.depth_decay));
          offset <= offset + OFF_W'(cfg.delay_length);
          tap    <= tap + 1'b1;
          if (tap == TAP_W'(mtbd_pkg::TAP_COUNT - 1)) begin
            state <= ST_MIX;
          end else begin
            state <= ST_GAIN;
          end
        end
        ST_MIX: begin
          dry_term_l <= dry_l * $signed({1'b0, inv_mix});
          dry_term_r <= dry_r * $signed({1'b0, inv_mix});
          wet_term_l <= wet_l * $signed({1'b0, mix_c});
          wet_term_r <= wet_r * $signed({1'b0, mix_c});
          state      <= ST_SUM;
        end
        ST_SUM: begin
          res.left_out  <= sat_mix(sum_l);
          res.right_out <= stereo ? sat_mix(sum_r) : '0;
          hold_cnt      <= hold_next;
          head          <= head_next;
          state         <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A tap is only read with a depth of at least one bit.
  a_read_depth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DATA) |-> (bits >= 7'sd1))
    else $error("tap read with a depth below one bit");

  // Once a tap is taken its gain is below Q15 one and at or above the cutoff.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (!gain[GAIN_W-1] && (gain >= GAIN_W'(mtbd_pkg::GAIN_FLOOR))))
    else $error("tap gain out of range");

  // The walk never goes past the last tap.
  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (32'(tap) <= 32'(mtbd_pkg::TAP_COUNT - 1)))
    else $error("tap index beyond the last tap");

endmodule

// File: sv/multitap_bitcrush_delay.sv
// ----------------------------------------------------------------------------
// multitap_bitcrush_delay
// Multi-tap stereo delay with per-tap sample-and-hold and bit crushing,
// mixed dry/wet with Q15 gains and saturated to 16 bits.
//
//   channel   signals                               payload
//   sample    sample_valid / sample_stall           sample_t (left_in, right_in)
//   mix       mix_valid / mix_stall                 mix_t (left_out, right_out)
//   config    psel penable pwrite paddr pwdata      prdata, pready always high
//
// After reset the delay memories are swept to zero, one address a cycle,
// over all LINE_DEPTH (262144) addresses; sample_stall stays high and config
// writes work. The taps are walked one at a time, as they share one memory
// port and one multiplier pair. One item is in work at a time; a finished
// result waits in the output register, so the next transfer can start while
// mix_stall is high.
// ----------------------------------------------------------------------------
module multitap_bitcrush_delay (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mtbd_pkg::PADDR_W-1:0]   paddr,
  input  logic [mtbd_pkg::PDATA_W-1:0]   pwdata,
  output logic [mtbd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  mtbd_pkg::sample_t              sample,
  output logic                           mix_valid,
  input  logic                           mix_stall,
  output mtbd_pkg::mix_t                 mix
);

  mtbd_pkg::cfg_t                       cfg;
  mtbd_pkg::ram_req_t                   ram;
  logic signed [mtbd_pkg::SAMPLE_W-1:0] rd_l;
  logic signed [mtbd_pkg::SAMPLE_W-1:0] rd_r;
  logic                                 slot_free;
  logic                                 res_valid;
  mtbd_pkg::mix_t                       res;

  mtbd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtbd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .ram          (ram),
    .rd_l         (rd_l),
    .rd_r         (rd_r),
    .slot_free    (slot_free),
    .res_valid    (res_valid),
    .res          (res)
  );

  mtbd_ram #(
    .ADDR_W (mtbd_pkg::ADDR_W),
    .DATA_W (mtbd_pkg::SAMPLE_W)
  ) u_left_ram (
    .clk   (clk),
    .we    (ram.we_l),
    .addr  (ram.addr),
    .wdata (ram.wdata_l),
    .rdata (rd_l)
  );

  mtbd_ram #(
    .ADDR_W (mtbd_pkg::ADDR_W),
    .DATA_W (mtbd_pkg::SAMPLE_W)
  ) u_right_ram (
    .clk   (clk),
    .we    (ram.we_r),
    .addr  (ram.addr),
    .wdata (ram.wdata_r),
    .rdata (rd_r)
  );

  // The output register is free when empty or when its result is being taken.
  assign slot_free = !mix_valid || !mix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (res_valid) begin
      mix_valid <= 1'b1;
    end else if (!mix_stall) begin
      mix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      mix <= res;
    end
  end

endmodule
